// ===== hw/rtl/cfq_pkg.sv =====
package cfq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int WORD_W      = 32;
    localparam int CAP_W       = 5;
    localparam int OP_W        = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    // output word layout, lowest bit first
    localparam int OUT_ACC_BIT   = 0;
    localparam int OUT_HEAD_LSB  = 1;
    localparam int OUT_TAIL_LSB  = OUT_HEAD_LSB + WORD_W;
    localparam int OUT_EMPTY_BIT = OUT_TAIL_LSB + WORD_W;
    localparam int OUT_FULL_BIT  = OUT_EMPTY_BIT + 1;
    localparam int OUT_USED_W    = OUT_FULL_BIT + 1;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic flush;
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/cfq_cell.sv =====
module cfq_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cfq_pkg::t_cell_ctl              i_ctl,
    input  logic [cfq_pkg::WORD_W-1:0]      i_value,
    input  logic [cfq_pkg::WORD_W-1:0]      i_next_word,
    input  logic                            i_next_valid,
    input  logic                            i_prev_valid,
    output logic [cfq_pkg::WORD_W-1:0]      o_word,
    output logic                            o_valid
);

    logic [cfq_pkg::WORD_W-1:0] r_word;
    logic [cfq_pkg::WORD_W-1:0] n_word;
    logic                       r_valid;
    logic                       n_valid;
    logic                       take;

    // the first empty cell behind a filled one takes the new word
    assign take = i_ctl.load & ~r_valid & i_prev_valid;

    always_comb begin
        n_word  = r_word;
        n_valid = r_valid;
        if (i_ctl.flush) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_word  = i_next_word;
            n_valid = i_next_valid;
        end else if (take) begin
            n_word  = i_value;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/circular_fifo_queue_unit.sv =====
// Latency: a result word is valid the cycle after its input word is taken.
// Throughput: one word per cycle unless stalled; queue state is a chain of DEPTH
// cells that shift toward the head on dequeue, fill the first free on enqueue.
// Reset (synchronous, active low): queue empty, capacity 16, no result pending.
// A capacity write flushes the queue in the same cycle.
module circular_fifo_queue_unit #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [cfq_pkg::CAP_W-1:0]           i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cfq_pkg::WORD_W-1:0]          s_axis_tdata,  // [31:0] value
    input  logic [cfq_pkg::OP_W-1:0]            s_axis_tuser,  // [1:0] op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] accepted, [32:1] head_word, [64:33] tail_word, [65] is_empty,
    // [66] is_full, rest zero
    output logic [cfq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > cfq_pkg::CAP_W) ? CNT_W : cfq_pkg::CAP_W;
    localparam int W     = cfq_pkg::WORD_W;

    logic [cfq_pkg::CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [W-1:0]               r_tail;
    logic                       r_out_valid;
    logic [cfq_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [cfq_pkg::OUT_TDATA_W-1:0] n_out_data;

    logic [CMP_W-1:0]           cap_ext;
    logic [CNT_W-1:0]           eff_cap;
    logic                       take_in;
    logic                       is_empty;
    logic                       is_full;
    logic                       enq_ok;
    logic                       deq_ok;
    logic                       ok;
    logic                       n_empty;
    logic                       n_full;
    logic [W-1:0]               n_head;
    logic [W-1:0]               n_tail;
    cfq_pkg::t_cell_ctl         cell_ctl;

    logic [W-1:0]               chain_word  [DEPTH+1];
    logic                       chain_valid [DEPTH+1];

    assign cap_ext = CMP_W'(r_cap);

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(cap_ext);
        end
    end

    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign take_in       = s_axis_tvalid & s_axis_tready;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == eff_cap);
    assign enq_ok   = (s_axis_tuser == cfq_pkg::OP_ENQ) & ~is_full;
    assign deq_ok   = (s_axis_tuser == cfq_pkg::OP_DEQ) & ~is_empty;
    assign ok       = ~(((s_axis_tuser == cfq_pkg::OP_ENQ) & is_full) |
                        ((s_axis_tuser == cfq_pkg::OP_DEQ) & is_empty));

    always_comb begin
        n_count = r_count;
        if (take_in && enq_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (take_in && deq_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign n_empty = (n_count == '0);
    assign n_full  = (n_count == eff_cap);

    always_comb begin
        if (n_empty) begin
            n_head = cfq_pkg::EMPTY_WORD;
        end else if (enq_ok && is_empty) begin
            n_head = s_axis_tdata;
        end else if (deq_ok) begin
            n_head = chain_word[1];
        end else begin
            n_head = chain_word[0];
        end
    end

    always_comb begin
        if (n_empty) begin
            n_tail = cfq_pkg::EMPTY_WORD;
        end else if (enq_ok) begin
            n_tail = s_axis_tdata;
        end else begin
            n_tail = r_tail;
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[cfq_pkg::OUT_ACC_BIT]                = ok;
        n_out_data[cfq_pkg::OUT_HEAD_LSB +: W]          = n_head;
        n_out_data[cfq_pkg::OUT_TAIL_LSB +: W]          = n_tail;
        n_out_data[cfq_pkg::OUT_EMPTY_BIT]              = n_empty;
        n_out_data[cfq_pkg::OUT_FULL_BIT]               = n_full;
    end

    always_comb begin
        cell_ctl.flush = i_cfg_wen;
        cell_ctl.shift = take_in & deq_ok;
        cell_ctl.load  = take_in & enq_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= cfq_pkg::CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_cap   <= i_cfg_wdata;
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
            if (take_in) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_out_data <= n_out_data;
        end
        if (take_in && enq_ok) begin
            r_tail <= s_axis_tdata;
        end
    end

    // end of the chain feeds an empty cell on shift
    assign chain_word[DEPTH]  = '0;
    assign chain_valid[DEPTH] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic prev_valid;
        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = chain_valid[g-1];
        end

        cfq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_value      (s_axis_tdata),
            .i_next_word  (chain_word[g+1]),
            .i_next_valid (chain_valid[g+1]),
            .i_prev_valid (prev_valid),
            .o_word       (chain_word[g]),
            .o_valid      (chain_valid[g])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/cfq_chk.sv =====
module cfq_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [cfq_pkg::OP_W-1:0]         s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cfq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int W = cfq_pkg::WORD_W;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // empty queue reports -1 for both ends
    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[cfq_pkg::OUT_EMPTY_BIT] |->
            m_axis_tdata[cfq_pkg::OUT_HEAD_LSB +: W] == cfq_pkg::EMPTY_WORD &&
            m_axis_tdata[cfq_pkg::OUT_TAIL_LSB +: W] == cfq_pkg::EMPTY_WORD)
        else $error("empty queue with head or tail other than -1");

    // capacity is at least one, so empty and full exclude each other
    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            !(m_axis_tdata[cfq_pkg::OUT_EMPTY_BIT] && m_axis_tdata[cfq_pkg::OUT_FULL_BIT]))
        else $error("queue reported empty and full at once");

    // a query is always accepted and answered in the next cycle
    a_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == cfq_pkg::OP_QUERY |=>
            m_axis_tvalid && m_axis_tdata[cfq_pkg::OUT_ACC_BIT])
        else $error("query not answered as accepted");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind circular_fifo_queue_unit cfq_chk u_cfq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
